### hdl/brm_pkg.sv
package brm_pkg;

   localparam int BytesWidth  = 64;
   localparam int TimeWidth   = 32;
   localparam int RateWidth   = 32;
   localparam int SmoothWidth = 40;
   localparam int FracWidth   = 8;
   localparam int WeightWidth = 9;
   localparam int CsrWidth    = 16;
   localparam int AccWidth    = SmoothWidth + WeightWidth;

   localparam logic [CsrWidth-1:0]    MIN_INTERVAL_RESET = 16'd250;
   localparam logic [CsrWidth-1:0]    HOLD_RESET         = 16'd3000;
   localparam logic [WeightWidth-1:0] WEIGHT_RESET       = 9'd102;
   localparam logic [WeightWidth-1:0] WEIGHT_FULL        = 9'd256;
   localparam logic [RateWidth-1:0]   RATE_MAX           = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CSR_MIN_INTERVAL = 2'd0,
      CSR_HOLD         = 2'd1,
      CSR_EMA_WEIGHT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  sample_valid;
      logic [BytesWidth-1:0] byte_count;
      logic [TimeWidth-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic                 rate_valid;
      logic [RateWidth-1:0] rate_kbps;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [BytesWidth-1:0] dividend;
      logic [TimeWidth-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [RateWidth-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                   start;
      logic [SmoothWidth-1:0] smoothed;
      logic [RateWidth-1:0]   inst;
      logic [WeightWidth-1:0] weight;
   } ema_req_type;

   typedef struct packed {
      logic                   done;
      logic [SmoothWidth-1:0] smoothed;
   } ema_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_EMA  = 5'b01000,
      ST_SEND = 5'b10000
   } state_type;

endpackage

### hdl/brm_div.sv
module brm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  brm_pkg::div_req_type div_req,
   output brm_pkg::div_rsp_type div_rsp
);
   import brm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [BytesWidth-1:0] dvd_ff, dvd_in;
   logic [TimeWidth-1:0]  dvs_ff, dvs_in;
   logic [TimeWidth-1:0]  rem_ff, rem_in;
   logic [RateWidth-1:0]  quo_ff, quo_in;
   logic                  ovf_ff, ovf_in;
   logic [TimeWidth:0]    trial;
   logic [TimeWidth:0]    diff;
   logic                  ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[BytesWidth-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[TimeWidth-1:0] : trial[TimeWidth-1:0];
         quo_in = {quo_ff[RateWidth-2:0], ge};
         ovf_in = ovf_ff | (ge & ~cnt_ff[5]);
         dvd_in = {dvd_ff[BytesWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = ovf_ff ? RATE_MAX : quo_ff;

endmodule

### hdl/brm_ema.sv
module brm_ema (
   input  logic                 clock,
   input  logic                 reset,
   input  brm_pkg::ema_req_type ema_req,
   output brm_pkg::ema_rsp_type ema_rsp
);
   import brm_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [AccWidth-1:0]    acc_ff, acc_in;
   logic [AccWidth-1:0]    mcand_ff, mcand_in;
   logic [WeightWidth-1:0] mplier_ff, mplier_in;
   logic [RateWidth-1:0]   inst_ff, inst_in;
   logic [WeightWidth-1:0] wgt_ff, wgt_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      inst_in   = inst_ff;
      wgt_in    = wgt_ff;
      if (ema_req.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = {{WeightWidth{1'b0}}, ema_req.smoothed};
         mplier_in = WEIGHT_FULL - ema_req.weight;
         inst_in   = ema_req.inst;
         wgt_in    = ema_req.weight;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd8) begin
            mcand_in  = {{(AccWidth-RateWidth-FracWidth){1'b0}}, inst_ff, {FracWidth{1'b0}}};
            mplier_in = wgt_ff;
         end else begin
            mcand_in  = {mcand_ff[AccWidth-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[WeightWidth-1:1]};
         end
         if (cnt_ff == 5'd17) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      inst_ff   <= inst_in;
      wgt_ff    <= wgt_in;
   end

   assign ema_rsp.done     = done_ff;
   assign ema_rsp.smoothed = acc_ff[SmoothWidth+FracWidth-1:FracWidth];

endmodule

### hdl/byte_counter_rate_meter_top.sv
// Byte-counter rate meter: one result per sample, giving the smoothed receive
// rate in kbit/s and a flag that says whether it should be shown. A sample
// that does not move the baseline goes from the evaluation state straight to
// the send state, which registers the result; a sample that computes a new
// rate runs the bit-serial divider (delta*8/elapsed), then the shift-add
// smoothing multiplier, or only the divider if the average loads unsmoothed.
// One sample is worked on at a time; a new sample is taken while the previous
// result waits in the output register. Configuration writes take effect at
// once and belong between samples.
module byte_counter_rate_meter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  brm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output brm_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import brm_pkg::*;

   state_type              state_ff, state_in;
   req_type                req_ff;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [CsrWidth-1:0]    min_ff;
   logic [CsrWidth-1:0]    hold_ff;
   logic [WeightWidth-1:0] weight_ff;

   logic                   baseline_ff, baseline_in;
   logic [BytesWidth-1:0]  prev_bytes_ff, prev_bytes_in;
   logic [TimeWidth-1:0]   prev_time_ff, prev_time_in;
   logic [TimeWidth-1:0]   move_time_ff, move_time_in;
   logic [SmoothWidth-1:0] smoothed_ff, smoothed_in;
   logic                   smooth_valid_ff, smooth_valid_in;
   logic                   flow_ff, flow_in;
   logic                   sat_ff, sat_in;

   logic [TimeWidth-1:0]   elapsed;
   logic [CsrWidth-1:0]    least;
   logic [BytesWidth-1:0]  delta;
   logic [TimeWidth-1:0]   age;
   logic                   show;
   logic [RateWidth-1:0]   inst;
   logic [WeightWidth-1:0] weight_sat;

   div_req_type            div_req;
   div_rsp_type            div_rsp;
   ema_req_type            ema_req;
   ema_rsp_type            ema_rsp;

   brm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   brm_ema u_ema (
      .clock   (clock),
      .reset   (reset),
      .ema_req (ema_req),
      .ema_rsp (ema_rsp)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      elapsed    = req_ff.now_ms - prev_time_ff;
      least      = (min_ff == '0) ? 16'd1 : min_ff;
      delta      = (req_ff.byte_count >= prev_bytes_ff) ?
                   (req_ff.byte_count - prev_bytes_ff) : '0;
      age        = req_ff.now_ms - move_time_ff;
      show       = smooth_valid_ff & flow_ff & (age < {16'b0, hold_ff});
      inst       = sat_ff ? RATE_MAX : div_rsp.quotient;
      weight_sat = weight_ff[WeightWidth-1] ? WEIGHT_FULL : weight_ff;

      state_in        = state_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      baseline_in     = baseline_ff;
      prev_bytes_in   = prev_bytes_ff;
      prev_time_in    = prev_time_ff;
      move_time_in    = move_time_ff;
      smoothed_in     = smoothed_ff;
      smooth_valid_in = smooth_valid_ff;
      flow_in         = flow_ff;
      sat_in          = sat_ff;

      div_req.start    = 1'b0;
      div_req.dividend = {delta[BytesWidth-4:0], 3'b000};
      div_req.divisor  = elapsed;
      ema_req.start    = 1'b0;
      ema_req.smoothed = smoothed_ff;
      ema_req.inst     = inst;
      ema_req.weight   = weight_sat;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!req_ff.sample_valid) begin
               baseline_in     = 1'b0;
               prev_bytes_in   = '0;
               prev_time_in    = '0;
               move_time_in    = '0;
               smoothed_in     = '0;
               smooth_valid_in = 1'b0;
               flow_in         = 1'b0;
               state_in        = ST_SEND;
            end else if (!baseline_ff) begin
               baseline_in   = 1'b1;
               prev_bytes_in = req_ff.byte_count;
               prev_time_in  = req_ff.now_ms;
               move_time_in  = req_ff.now_ms;
               state_in      = ST_SEND;
            end else if (elapsed >= {16'b0, least}) begin
               if (delta != '0) begin
                  move_time_in = req_ff.now_ms;
                  flow_in      = 1'b1;
               end
               sat_in        = |delta[BytesWidth-1:BytesWidth-3];
               div_req.start = 1'b1;
               prev_bytes_in = req_ff.byte_count;
               prev_time_in  = req_ff.now_ms;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (smooth_valid_ff) begin
                  ema_req.start = 1'b1;
                  state_in      = ST_EMA;
               end else begin
                  smoothed_in     = {inst, {FracWidth{1'b0}}};
                  smooth_valid_in = 1'b1;
                  state_in        = ST_SEND;
               end
            end
         end
         ST_EMA: begin
            if (ema_rsp.done) begin
               smoothed_in = ema_rsp.smoothed;
               state_in    = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.rate_valid = show;
               rsp_in.rate_kbps  = show ? smoothed_ff[SmoothWidth-1:FracWidth] : '0;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         min_ff          <= MIN_INTERVAL_RESET;
         hold_ff         <= HOLD_RESET;
         weight_ff       <= WEIGHT_RESET;
         baseline_ff     <= 1'b0;
         prev_bytes_ff   <= '0;
         prev_time_ff    <= '0;
         move_time_ff    <= '0;
         smoothed_ff     <= '0;
         smooth_valid_ff <= 1'b0;
         flow_ff         <= 1'b0;
         sat_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         baseline_ff     <= baseline_in;
         prev_bytes_ff   <= prev_bytes_in;
         prev_time_ff    <= prev_time_in;
         move_time_ff    <= move_time_in;
         smoothed_ff     <= smoothed_in;
         smooth_valid_ff <= smooth_valid_in;
         flow_ff         <= flow_in;
         sat_ff          <= sat_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN_INTERVAL: min_ff    <= csr_wdata;
               CSR_HOLD:         hold_ff   <= csr_wdata;
               CSR_EMA_WEIGHT:   weight_ff <= csr_wdata[WeightWidth-1:0];
               default:          ;
            endcase
         end
      end
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   a_zero_when_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.rate_valid |-> rsp_ff.rate_kbps == '0)
      else $error("rate shown while flagged invalid");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample taken while one is in flight");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside its state");

   a_ema_done_in_ema: assert property (@(posedge clock) disable iff (reset)
      ema_rsp.done |-> state_ff == ST_EMA)
      else $error("smoothing finished outside its state");

   a_idle_average_clear: assert property (@(posedge clock) disable iff (reset)
      !smooth_valid_ff |-> smoothed_ff == '0)
      else $error("average holds a value while invalid");

endmodule
